/* src/dq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command, status and cell operation codes shared by the queue modules.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Fixed field widths of the request and result channels.
  localparam int CMD_BITS    = 3;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int OCC_BITS    = 5;

  // Request commands.
  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD,        // keep contents
    OP_SHIFT_IN,    // every cell takes its front-side neighbour (push front)
    OP_SHIFT_OUT,   // every cell takes its back-side neighbour (pop front)
    OP_WRITE_BACK,  // the first free cell takes the broadcast data
    OP_ROTATE       // occupied cells move one place frontwards, tail takes head
  } cell_op_t;

endpackage

/* src/dq_in_if.sv */
// ----------------------------------------------------------------------------
// Queue request channel
// Valid/ready channel carrying one command and its push value.
// ----------------------------------------------------------------------------
interface dq_in_if;
  import dq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_BITS-1:0]   command;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, output command, output value_in, input ready);
  modport sink   (input valid, input command, input value_in, output ready);

endinterface

/* src/dq_out_if.sv */
// ----------------------------------------------------------------------------
// Queue result channel
// Valid/ready channel carrying one result of a command.
// ----------------------------------------------------------------------------
interface dq_out_if;
  import dq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  value_out;
  logic [STATUS_BITS-1:0] status;
  logic [OCC_BITS-1:0]    occupancy;
  logic                   last_of_run;

  modport source (output valid, output value_out, output status, output occupancy,
                  output last_of_run, input ready);
  modport sink   (input valid, input value_out, input status, input occupancy,
                  input last_of_run, output ready);

endinterface

/* src/dq_cell.sv */
// ----------------------------------------------------------------------------
// Queue storage cell
// Holds one queue position and moves data to and from its neighbours.
// ----------------------------------------------------------------------------
module dq_cell
  import dq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5,
  parameter int W   = 32
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [CW-1:0] count,
  input  logic [W-1:0]  data,
  input  logic [W-1:0]  from_front,
  input  logic [W-1:0]  from_back,
  input  logic [W-1:0]  tail_in,
  output logic [W-1:0]  tail_out,
  output logic [W-1:0]  val
);

  localparam logic [CW-1:0] POS      = CW'(IDX);
  localparam logic [CW-1:0] POS_NEXT = CW'(IDX + 1);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;
  logic         is_tail;
  logic         is_inner;

  // Position relative to the current occupancy.
  assign is_tail  = (count == POS_NEXT);
  assign is_inner = (POS_NEXT < count);

  // The tail cell drives its value onto the chain for pops from the back.
  assign tail_out = tail_in | (is_tail ? val_r : '0);
  assign val      = val_r;

  // Next contents according to the broadcast operation.
  always_comb begin
    val_nxt = val_r;
    case (op)
      OP_SHIFT_IN:   val_nxt = from_front;
      OP_SHIFT_OUT:  val_nxt = from_back;
      OP_WRITE_BACK: if (count == POS) val_nxt = data;
      OP_ROTATE: begin
        if (is_inner)     val_nxt = from_back;
        else if (is_tail) val_nxt = data;
      end
      default:       val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* src/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of unsigned values held in a chain of storage cells.
// ----------------------------------------------------------------------------
// The queue keeps its values in a row of CAPACITY cells with the front value
// always in the first cell. A push or pop at either end yields one result,
// and such requests are taken every cycle while the result register drains.
// A dump of n stored values gives n results, one result per cycle while the
// result register drains, during which the chain rotates once around its
// occupied cells and no request is taken. A push into a full queue is dropped
// with a full status, a pop or dump on an empty queue reports empty, and
// commands five to seven are taken without a result. A result waits in an
// output register, and while it is held there untaken no request is
// accepted. The reset is synchronous and active low; it empties the queue
// without touching the cells.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  dq_in_if.sink    in_chan,
  dq_out_if.source out_chan
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] dump_left_r, dump_left_nxt;

  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_value_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [OCC_BITS-1:0]    out_occ_r;
  logic                   out_last_r;

  logic                   advance;
  logic                   accept;
  cell_op_t               op;
  logic [SW-1:0]          push_val;
  logic [SW-1:0]          head_val;
  logic [SW-1:0]          tail_val;
  logic [SW-1:0]          bcast;
  logic                   res_valid;
  logic [SW-1:0]          res_value;
  status_t                res_status;
  logic [CW-1:0]          res_occ;
  logic                   res_last;

  logic [SW-1:0] cell_val   [CAPACITY];
  logic [SW-1:0] tail_chain [CAPACITY+1];

  // Handshake: the result register moves on when empty or being taken.
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance && (dump_left_r == '0);
  assign accept        = in_chan.valid && in_chan.ready;
  assign push_val      = in_chan.value_in[SW-1:0];
  assign head_val      = cell_val[0];
  assign tail_val      = tail_chain[CAPACITY];
  assign bcast         = (op == OP_ROTATE) ? head_val : push_val;
  assign tail_chain[0] = '0;

  // Row of storage cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] front_side;
    logic [SW-1:0] back_side;

    if (i == 0) begin : g_first
      assign front_side = push_val;
    end else begin : g_mid
      assign front_side = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign back_side = '0;
    end else begin : g_inner
      assign back_side = cell_val[i+1];
    end

    dq_cell #(
      .IDX (i),
      .CW  (CW),
      .W   (SW)
    ) u_cell (
      .clk        (clk),
      .op         (op),
      .count      (count_r),
      .data       (bcast),
      .from_front (front_side),
      .from_back  (back_side),
      .tail_in    (tail_chain[i]),
      .tail_out   (tail_chain[i+1]),
      .val        (cell_val[i])
    );
  end

  // Command decode and result formation.
  always_comb begin
    op            = OP_HOLD;
    count_nxt     = count_r;
    dump_left_nxt = dump_left_r;
    res_valid     = 1'b0;
    res_value     = '0;
    res_status    = ST_OK;
    res_occ       = count_r;
    res_last      = 1'b1;
    if (accept) begin
      unique case (in_chan.command) inside
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          res_valid = 1'b1;
          if (count_r == CAP) begin
            res_status = ST_FULL;
          end else begin
            op        = (in_chan.command == CMD_PUSH_FRONT) ? OP_SHIFT_IN : OP_WRITE_BACK;
            count_nxt = count_r + ONE;
            res_occ   = count_nxt;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          res_valid = 1'b1;
          if (count_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            op        = (in_chan.command == CMD_POP_FRONT) ? OP_SHIFT_OUT : OP_HOLD;
            res_value = (in_chan.command == CMD_POP_FRONT) ? head_val : tail_val;
            count_nxt = count_r - ONE;
            res_occ   = count_nxt;
          end
        end
        CMD_DUMP: begin
          res_valid = 1'b1;
          if (count_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            op            = OP_ROTATE;
            res_value     = head_val;
            res_last      = (count_r == ONE);
            dump_left_nxt = count_r - ONE;
          end
        end
        default: ;
      endcase
    end else if ((dump_left_r != '0) && advance) begin
      op            = OP_ROTATE;
      res_valid     = 1'b1;
      res_value     = head_val;
      res_last      = (dump_left_r == ONE);
      dump_left_nxt = dump_left_r - ONE;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      dump_left_r <= dump_left_nxt;
      if (advance) out_valid_r <= res_valid;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_value_r  <= VALUE_BITS'(res_value);
      out_status_r <= res_status;
      out_occ_r    <= OCC_BITS'(res_occ);
      out_last_r   <= res_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.value_out   = out_value_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.occupancy   = out_occ_r;
  assign out_chan.last_of_run = out_last_r;

  // The occupancy never exceeds the number of cells.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP)
    else $error("queue occupancy above capacity");

  // A dump in progress has fewer values left to emit than the queue holds.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (dump_left_r == '0) || (dump_left_r < count_r))
    else $error("dump counter out of range");

  // No request is taken while a dump is still emitting.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (dump_left_r != '0) |-> !in_chan.ready)
    else $error("request accepted during a dump");

  // An accepted push into a queue with room grows it by one.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (accept && (count_r != CAP) &&
                    ((in_chan.command == CMD_PUSH_FRONT) ||
                     (in_chan.command == CMD_PUSH_BACK)))
                   |=> (count_r == $past(count_r) + ONE))
    else $error("push did not grow the queue");

endmodule
